### design/spe_pkg.sv
// Shared constants for the sphere point evaluator: register indexes, reset values,
// widths and the CORDIC arctangent table. No dependencies.
package spe_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_Z  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd6;

  localparam logic [30:0] RADIUS_RST  = 31'd65536;
  localparam logic [47:0] FRAME_X_RST = 48'h0000_0000_4000;
  localparam logic [47:0] FRAME_Y_RST = 48'h0000_4000_0000;
  localparam logic [47:0] FRAME_Z_RST = 48'h4000_0000_0000;

  // Integer square root: radicand below 2^62, one root bit per stage
  localparam int unsigned ISQ_IN_W  = 62;
  localparam int unsigned ISQ_OUT_W = 31;
  localparam int unsigned ISQ_STEPS = 31;

  // CORDIC rotation on Q1.30 values, angle as 32-bit binary angle
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned CORDIC_W     = 34;
  localparam logic signed [CORDIC_W-1:0] CORDIC_START = 34'sd652032875;
  localparam logic signed [16:0] QUARTER_TURN = 17'sd16384;
  localparam logic signed [16:0] HALF_TURN    = 17'sd32768;
  localparam logic signed [CORDIC_W-1:0] CORDIC_ATAN [CORDIC_STEPS] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667330,  34'sd21354465,  34'sd10679839,  34'sd5340245,
    34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
    34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861
  };

  // Normal divider: numerator mag*2^14 + n/2, divisor n
  localparam int unsigned DIV_NUM_W = 45;
  localparam int unsigned DIV_DEN_W = 31;
  localparam int unsigned DIV_Q_W   = 16;
  localparam int unsigned DIV_STEPS = 16;

  localparam logic [DIV_Q_W-1:0] NORM_ONE = 16'd16384;

endpackage

### design/spe_delay.sv
// Enable-gated delay line that carries side data alongside the pipeline.
// No package dependency.
module spe_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] pipe_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        pipe_q[i] <= pipe_q[i-1];
      end
    end
  end

  assign q_o = pipe_q[DEPTH-1];

endmodule

### design/spe_isqrt.sv
// Pipelined integer square root, rounded down, one root bit per stage.
// Depends on spe_pkg.
module spe_isqrt (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [spe_pkg::ISQ_IN_W-1:0]   rad_i,
  output logic [spe_pkg::ISQ_OUT_W-1:0]  root_o
);
  import spe_pkg::*;

  logic [ISQ_IN_W-1:0] rem_q [ISQ_STEPS-1];
  logic [ISQ_IN_W-1:0] res_q [ISQ_STEPS];

  for (genvar j = 0; j < ISQ_STEPS; j++) begin : g_step
    localparam logic [ISQ_IN_W-1:0] BIT = ISQ_IN_W'(1) << (2 * (ISQ_STEPS - 1 - j));
    logic [ISQ_IN_W-1:0] rem_in, res_in, res_sh;
    logic [ISQ_IN_W:0]   trial;
    logic                take;

    if (j == 0) begin : g_first
      assign rem_in = rad_i;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign res_in = res_q[j-1];
    end

    always_comb begin
      trial  = {1'b0, res_in} + {1'b0, BIT};
      take   = {1'b0, rem_in} >= trial;
      res_sh = res_in >> 1;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        res_q[j] <= take ? res_sh + BIT : res_sh;
      end
    end

    if (j < ISQ_STEPS - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= take ? rem_in - trial[ISQ_IN_W-1:0] : rem_in;
        end
      end
    end
  end

  assign root_o = res_q[ISQ_STEPS-1][ISQ_OUT_W-1:0];

endmodule

### design/spe_cordic.sv
// Pipelined CORDIC giving cosine and sine of a 16-bit binary angle in Q1.30.
// Depends on spe_pkg.
module spe_cordic (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [15:0] azimuth_i,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);
  import spe_pkg::*;

  logic signed [16:0]         fold;
  logic                       fold_neg;
  logic signed [CORDIC_W-1:0] zp_q;
  logic                       negp_q;

  logic signed [CORDIC_W-1:0] x_q [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] y_q [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] z_q [CORDIC_STEPS-1];
  logic                       neg_q [CORDIC_STEPS];
  logic signed [31:0]         cos_q, sin_q;

  // Fold beyond a quarter turn by a half turn; negate both results at the end
  always_comb begin
    fold     = 17'(azimuth_i);
    fold_neg = 1'b0;
    if (fold > QUARTER_TURN) begin
      fold     = fold - HALF_TURN;
      fold_neg = 1'b1;
    end else if (fold < -QUARTER_TURN) begin
      fold     = fold + HALF_TURN;
      fold_neg = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zp_q   <= {fold[16], fold, 16'b0};
      negp_q <= fold_neg;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    logic signed [CORDIC_W-1:0] x_in, y_in, z_in, dx, dy;
    logic                       n_in;

    if (i == 0) begin : g_first
      assign x_in = CORDIC_START;
      assign y_in = '0;
      assign z_in = zp_q;
      assign n_in = negp_q;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
      assign n_in = neg_q[i-1];
    end

    assign dx = y_in >>> i;
    assign dy = x_in >>> i;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[i] <= n_in;
        if (!z_in[CORDIC_W-1]) begin
          x_q[i] <= x_in - dx;
          y_q[i] <= y_in + dy;
        end else begin
          x_q[i] <= x_in + dx;
          y_q[i] <= y_in - dy;
        end
      end
    end

    if (i < CORDIC_STEPS - 1) begin : g_z
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          z_q[i] <= z_in[CORDIC_W-1] ? z_in + CORDIC_ATAN[i] : z_in - CORDIC_ATAN[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= neg_q[CORDIC_STEPS-1] ? 32'(-x_q[CORDIC_STEPS-1]) : 32'(x_q[CORDIC_STEPS-1]);
      sin_q <= neg_q[CORDIC_STEPS-1] ? 32'(-y_q[CORDIC_STEPS-1]) : 32'(y_q[CORDIC_STEPS-1]);
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

### design/spe_ndiv.sv
// Pipelined restoring divider for one normal component, one quotient bit per stage.
// Depends on spe_pkg.
module spe_ndiv (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [spe_pkg::DIV_NUM_W-1:0] num_i,
  input  logic [spe_pkg::DIV_DEN_W-1:0] den_i,
  output logic [spe_pkg::DIV_Q_W-1:0]   quot_o
);
  import spe_pkg::*;

  logic [DIV_DEN_W-1:0] rem_q [DIV_STEPS-1];
  logic [DIV_Q_W-1:0]   low_q [DIV_STEPS-1];
  logic [DIV_DEN_W-1:0] den_q [DIV_STEPS-1];
  logic [DIV_Q_W-1:0]   quo_q [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic [DIV_DEN_W-1:0] rem_in, den_in;
    logic [DIV_Q_W-1:0]   low_in, quo_in;
    logic [DIV_DEN_W:0]   trial;
    logic                 take;

    if (j == 0) begin : g_first
      assign rem_in = DIV_DEN_W'(num_i[DIV_NUM_W-1:DIV_Q_W]);
      assign low_in = num_i[DIV_Q_W-1:0];
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign low_in = low_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    assign trial = {rem_in, low_in[DIV_Q_W-1]};
    assign take  = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[j] <= {quo_in[DIV_Q_W-2:0], take};
      end
    end

    if (j < DIV_STEPS - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= take ? DIV_DEN_W'(trial - {1'b0, den_in}) : DIV_DEN_W'(trial);
          low_q[j] <= low_in << 1;
          den_q[j] <= den_in;
        end
      end
    end
  end

  assign quot_o = quo_q[DIV_STEPS-1];

endmodule

### design/sphere_point_evaluate_core.sv
// Sphere point evaluator: maps (height, azimuth) to a surface point and inward normal.
// Depends on spe_pkg, spe_delay, spe_isqrt, spe_cordic and spe_ndiv.
//
// One beat is accepted per clock and one result beat leaves per clock once the
// pipeline is full, except while the pipeline holds. Each beat passes through the
// two 31-stage square-root pipelines (ring radius, then the normal length) and
// the 16-stage normal divider, all in series. Every stage moves on one shared
// enable; a finished result sits in the output register while the pipeline
// keeps taking beats, and the pipeline holds only when its last stage is
// full and the output register is still waiting. Configuration registers are
// written with cfg_we_i/cfg_idx_i/cfg_data_i and must only change while no beat is
// in flight. A height whose square exceeds the squared radius raises invalid_o and
// puts the point on the axis. A zero local vector gives a zero normal.
module sphere_point_evaluate_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [spe_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [spe_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [31:0]             height_i,
  input  logic signed [15:0]             azimuth_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [31:0]             point_x_o,
  output logic signed [31:0]             point_y_o,
  output logic signed [31:0]             point_z_o,
  output logic signed [15:0]             normal_x_o,
  output logic signed [15:0]             normal_y_o,
  output logic signed [15:0]             normal_z_o,
  output logic                           invalid_o
);
  import spe_pkg::*;

  // Stage numbering: stage 0 is the input register
  localparam int unsigned ST_RAD     = 2;
  localparam int unsigned ST_RING    = ST_RAD + ISQ_STEPS;
  localparam int unsigned CORDIC_LAT = CORDIC_STEPS + 2;
  localparam int unsigned ST_RCS     = ST_RING + 1;
  localparam int unsigned ST_MAG     = ST_RCS + 3;
  localparam int unsigned ST_SHF     = ST_MAG + 2;
  localparam int unsigned ST_SUM     = ST_SHF + 2;
  localparam int unsigned ST_NRM     = ST_SUM + ISQ_STEPS;
  localparam int unsigned ST_NUM     = ST_NRM + 1;
  localparam int unsigned ST_DIV     = ST_NUM + DIV_STEPS;
  localparam int unsigned ST_LAST    = ST_DIV + 1;

  // ---------------------------------------------------------------- config
  logic [30:0]        radius_q;
  logic [47:0]        dir_x_q, dir_y_q, dir_z_q;
  logic signed [31:0] ctr_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      dir_x_q  <= FRAME_X_RST;
      dir_y_q  <= FRAME_Y_RST;
      dir_z_q  <= FRAME_Z_RST;
      ctr_q[0] <= '0;
      ctr_q[1] <= '0;
      ctr_q[2] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RADIUS:   radius_q <= cfg_data_i[30:0];
        REG_FRAME_X:  dir_x_q  <= cfg_data_i;
        REG_FRAME_Y:  dir_y_q  <= cfg_data_i;
        REG_FRAME_Z:  dir_z_q  <= cfg_data_i;
        REG_CENTER_X: ctr_q[0] <= cfg_data_i[31:0];
        REG_CENTER_Y: ctr_q[1] <= cfg_data_i[31:0];
        REG_CENTER_Z: ctr_q[2] <= cfg_data_i[31:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // ---------------------------------------------------------------- flow
  logic [ST_LAST:0] vld_q;
  logic             en;
  logic             out_valid_q;
  logic             out_take;

  // Advance unless the last stage is full and the output register is blocked
  assign out_take   = !out_valid_q || out_ready_i;
  assign en         = !vld_q[ST_LAST] || out_take;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (en) begin
        vld_q <= {vld_q[ST_LAST-1:0], in_valid_i};
      end
      if (out_take) begin
        out_valid_q <= vld_q[ST_LAST];
      end
    end
  end

  // ---------------------------------------------------------------- stage 0
  logic signed [31:0] h0_q;
  logic signed [15:0] az0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      h0_q  <= height_i;
      az0_q <= azimuth_i;
    end
  end

  // ---------------------------------------------------------------- ring radius
  logic [31:0]          hmag;
  logic [61:0]          r2_q;
  logic [63:0]          h2_q;
  logic                 inv2_q;
  logic [ISQ_IN_W-1:0]  rad_q;
  logic [ISQ_OUT_W-1:0] ring;

  assign hmag = h0_q[31] ? 32'(-h0_q) : 32'(h0_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      r2_q   <= radius_q * radius_q;
      h2_q   <= hmag * hmag;
      inv2_q <= h2_q > {2'b0, r2_q};
      rad_q  <= (h2_q > {2'b0, r2_q}) ? '0 : r2_q - h2_q[61:0];
    end
  end

  spe_isqrt u_ring_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad_q),
    .root_o (ring)
  );

  // ---------------------------------------------------------------- sin/cos
  logic signed [31:0] cos_c, sin_c;
  logic [63:0]        cs_d;

  spe_cordic u_cordic (
    .clk_i     (clk_i),
    .en_i      (en),
    .azimuth_i (az0_q),
    .cos_o     (cos_c),
    .sin_o     (sin_c)
  );

  // Hold cos/sin until the ring radius catches up
  spe_delay #(.WIDTH(64), .DEPTH(ST_RING - CORDIC_LAT)) u_cs_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({cos_c, sin_c}),
    .q_o   (cs_d)
  );

  logic [31:0] h_d;

  spe_delay #(.WIDTH(32), .DEPTH(ST_RCS)) u_h_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (h0_q),
    .q_o   (h_d)
  );

  // ---------------------------------------------------------------- r*cos, r*sin
  logic signed [63:0] rc_full, rs_full;
  logic signed [33:0] rc_q, rs_q;

  assign rc_full = $signed({1'b0, ring}) * $signed(cs_d[63:32]);
  assign rs_full = $signed({1'b0, ring}) * $signed(cs_d[31:0]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      rc_q <= rc_full[63:30];
      rs_q <= rs_full[63:30];
    end
  end

  // ---------------------------------------------------------------- frame products
  logic signed [49:0] prod_q [3][3];
  logic signed [51:0] loc_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        prod_q[k][0] <= $signed(dir_x_q[16*k +: 16]) * rc_q;
        prod_q[k][1] <= $signed(dir_y_q[16*k +: 16]) * rs_q;
        prod_q[k][2] <= $signed(dir_z_q[16*k +: 16]) * $signed(h_d);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        loc_q[k] <= 52'(prod_q[k][0]) + 52'(prod_q[k][1]) + 52'(prod_q[k][2]);
      end
    end
  end

  // ---------------------------------------------------------------- point, magnitudes
  logic signed [38:0] pt_sum [3];
  logic [31:0]        pt_q [3];
  logic [51:0]        mag_q [3];
  logic [2:0]         pos_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pt_sum[k] = 39'($signed(loc_q[k][51:14])) + 39'(ctr_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        // Saturate to signed 32 bits
        if (pt_sum[k] > 39'sd2147483647) begin
          pt_q[k] <= 32'h7FFF_FFFF;
        end else if (pt_sum[k] < -39'sd2147483648) begin
          pt_q[k] <= 32'h8000_0000;
        end else begin
          pt_q[k] <= pt_sum[k][31:0];
        end
        mag_q[k] <= loc_q[k][51] ? 52'(-loc_q[k]) : 52'(loc_q[k]);
        pos_q[k] <= !loc_q[k][51] && (loc_q[k] != '0);
      end
    end
  end

  // ---------------------------------------------------------------- normalize scale
  logic [51:0] mx_q;
  logic [51:0] magm_q [3];
  logic [5:0]  bitlen;
  logic [5:0]  shamt;
  logic [29:0] m30_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q <= (mag_q[0] > mag_q[1])
              ? ((mag_q[0] > mag_q[2]) ? mag_q[0] : mag_q[2])
              : ((mag_q[1] > mag_q[2]) ? mag_q[1] : mag_q[2]);
      for (int k = 0; k < 3; k++) begin
        magm_q[k] <= mag_q[k];
      end
    end
  end

  // Shift just far enough to bring the largest magnitude below 2^30
  always_comb begin
    bitlen = '0;
    for (int b = 0; b < 52; b++) begin
      if (mx_q[b]) begin
        bitlen = 6'(b + 1);
      end
    end
    shamt = (bitlen > 6'd30) ? bitlen - 6'd30 : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        m30_q[k] <= 30'(magm_q[k] >> shamt);
      end
    end
  end

  // ---------------------------------------------------------------- normal length
  logic [59:0]          sq_q [3];
  logic [ISQ_IN_W-1:0]  sum_q;
  logic [ISQ_OUT_W-1:0] nlen;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= m30_q[k] * m30_q[k];
      end
      sum_q <= {2'b0, sq_q[0]} + {2'b0, sq_q[1]} + {2'b0, sq_q[2]};
    end
  end

  spe_isqrt u_norm_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sum_q),
    .root_o (nlen)
  );

  logic [89:0] m30_d;

  spe_delay #(.WIDTH(90), .DEPTH(ST_NRM - ST_SHF)) u_m30_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({m30_q[2], m30_q[1], m30_q[0]}),
    .q_o   (m30_d)
  );

  // ---------------------------------------------------------------- divide
  logic [DIV_NUM_W-1:0] num_q [3];
  logic [DIV_DEN_W-1:0] den_q;
  logic                 nz_q;
  logic [DIV_Q_W-1:0]   quo [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        num_q[k] <= {1'b0, m30_d[30*k +: 30], 14'b0} + DIV_NUM_W'(nlen >> 1);
      end
      den_q <= nlen;
      nz_q  <= nlen != '0;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_div
    spe_ndiv u_ndiv (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (num_q[k]),
      .den_i  (den_q),
      .quot_o (quo[k])
    );
  end

  logic nz_d;
  logic [2:0] pos_d;

  spe_delay #(.WIDTH(1), .DEPTH(DIV_STEPS)) u_nz_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (nz_q),
    .q_o   (nz_d)
  );

  spe_delay #(.WIDTH(3), .DEPTH(ST_DIV - ST_MAG)) u_pos_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (pos_q),
    .q_o   (pos_d)
  );

  // ---------------------------------------------------------------- final stage
  logic [15:0] nrm_q [3];
  logic [15:0] qclip [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qclip[k] = !nz_d ? '0 : ((quo[k] > NORM_ONE) ? NORM_ONE : quo[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        // Inward normal: flip sign against the local vector
        nrm_q[k] <= pos_d[k] ? 16'(-qclip[k]) : qclip[k];
      end
    end
  end

  logic [95:0] pt_d;
  logic        inv_d;

  spe_delay #(.WIDTH(96), .DEPTH(ST_LAST - ST_MAG)) u_pt_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({pt_q[2], pt_q[1], pt_q[0]}),
    .q_o   (pt_d)
  );

  spe_delay #(.WIDTH(1), .DEPTH(ST_LAST - ST_RAD)) u_inv_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (inv2_q),
    .q_o   (inv_d)
  );

  // ---------------------------------------------------------------- output register
  logic [95:0] opt_q;
  logic [15:0] onrm_q [3];
  logic        oinv_q;

  always_ff @(posedge clk_i) begin
    if (out_take && vld_q[ST_LAST]) begin
      opt_q     <= pt_d;
      onrm_q[0] <= nrm_q[0];
      onrm_q[1] <= nrm_q[1];
      onrm_q[2] <= nrm_q[2];
      oinv_q    <= inv_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign point_x_o   = opt_q[31:0];
  assign point_y_o   = opt_q[63:32];
  assign point_z_o   = opt_q[95:64];
  assign normal_x_o  = onrm_q[0];
  assign normal_y_o  = onrm_q[1];
  assign normal_z_o  = onrm_q[2];
  assign invalid_o   = oinv_q;

endmodule

### tb/testbench.sv
// Self-checking testbench for sphere_point_evaluate_core: streams (height, azimuth)
// beats under several register settings and idle patterns and compares every result.
// Depends on spe_pkg and the design sources.
module testbench;
  import spe_pkg::*;

  // Index past the end of the register list; the block must ignore it.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int FLUSH_CYCLES = 120;
  localparam int CORDIC_ROUNDS = 16;
  localparam longint signed ATAN_Q30 [CORDIC_ROUNDS] = '{
    536870912, 316933406, 167458907, 85004756, 42667330, 21354465,
    10679839, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861
  };

  typedef struct packed {
    logic signed [31:0] height;
    logic signed [15:0] azimuth;
  } probe_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               invalid;
  } surface_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic signed [31:0]    height_i = '0;
  logic signed [15:0]    azimuth_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic signed [31:0]    point_x_o, point_y_o, point_z_o;
  logic signed [15:0]    normal_x_o, normal_y_o, normal_z_o;
  logic                  invalid_o;

  sphere_point_evaluate_core DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the register file as the block should hold it.
  logic [30:0]        sph_radius;
  logic [47:0]        sph_frame [3];
  logic signed [31:0] sph_center [3];

  probe_t   pending_probes[$];
  surface_t expected_surface[$];
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  bit       failed = 1'b0;

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint signed frame_comp(int axis, int k);
    logic signed [15:0] c;
    c = sph_frame[axis][16*k +: 16];
    return longint'(c);
  endfunction

  // Surface point and inward normal for one (height, azimuth) pair.
  function automatic surface_t evaluate_surface(probe_t p);
    surface_t res;
    longint signed hs, ring, az, x, y, z, dx, dy, rc, rs, v, q;
    longint signed loc [3];
    longint unsigned r2, hm, h2, mx, sum, n;
    longint unsigned mag [3];
    bit flip;
    int sh;
    hs = longint'(p.height);
    az = longint'(p.azimuth);
    r2 = longint'(sph_radius) * longint'(sph_radius);
    hm = hs < 0 ? -hs : hs;
    h2 = hm * hm;
    ring = 0;
    res.invalid = h2 > r2;
    if (!res.invalid) ring = floor_sqrt(r2 - h2);
    // Fold the angle into the right half plane, then rotate.
    flip = 1'b0;
    if (az > 16384) begin
      az -= 32768;
      flip = 1'b1;
    end else if (az < -16384) begin
      az += 32768;
      flip = 1'b1;
    end
    x = 652032875;
    y = 0;
    z = az * 65536;
    for (int i = 0; i < CORDIC_ROUNDS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_Q30[i];
      end else begin
        x += dx; y -= dy; z += ATAN_Q30[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    rc = (ring * x) >>> 30;
    rs = (ring * y) >>> 30;
    mx = 0;
    for (int k = 0; k < 3; k++) begin
      loc[k] = frame_comp(0, k) * rc + frame_comp(1, k) * rs + frame_comp(2, k) * hs;
      v = (loc[k] >>> 14) + longint'(sph_center[k]);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      case (k)
        0: res.point_x = v[31:0];
        1: res.point_y = v[31:0];
        default: res.point_z = v[31:0];
      endcase
      mag[k] = loc[k] < 0 ? -loc[k] : loc[k];
      if (mag[k] > mx) mx = mag[k];
    end
    sh = 0;
    while ((mx >> sh) >= (64'd1 << 30)) sh++;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      mag[k] >>= sh;
      sum += mag[k] * mag[k];
    end
    n = floor_sqrt(sum);
    for (int k = 0; k < 3; k++) begin
      q = 0;
      if (n != 0) begin
        q = (mag[k] * 16384 + n / 2) / n;
        if (q > 16384) q = 16384;
        if (loc[k] > 0) q = -q;
      end
      case (k)
        0: res.normal_x = q[15:0];
        1: res.normal_y = q[15:0];
        default: res.normal_z = q[15:0];
      endcase
    end
    return res;
  endfunction

  // Driver: predict on each accepted beat, then present the next one or idle.
  always @(posedge clk_i) begin
    probe_t nxt;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        expected_surface.push_back(evaluate_surface('{height_i, azimuth_i}));
      if (!in_valid_i || in_ready_o) begin
        if (pending_probes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_probes.pop_front();
          height_i   <= nxt.height;
          azimuth_i  <= nxt.azimuth;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest prediction, then stall at random.
  always @(posedge clk_i) begin
    surface_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_surface.size() == 0) begin
          $error("result beat with no prediction waiting");
          failed = 1'b1;
        end else begin
          want = expected_surface.pop_front();
          if (point_x_o !== want.point_x) begin
            $error("point_x expected %0d got %0d", want.point_x, point_x_o); failed = 1'b1;
          end
          if (point_y_o !== want.point_y) begin
            $error("point_y expected %0d got %0d", want.point_y, point_y_o); failed = 1'b1;
          end
          if (point_z_o !== want.point_z) begin
            $error("point_z expected %0d got %0d", want.point_z, point_z_o); failed = 1'b1;
          end
          if (normal_x_o !== want.normal_x) begin
            $error("normal_x expected %0d got %0d", want.normal_x, normal_x_o); failed = 1'b1;
          end
          if (normal_y_o !== want.normal_y) begin
            $error("normal_y expected %0d got %0d", want.normal_y, normal_y_o); failed = 1'b1;
          end
          if (normal_z_o !== want.normal_z) begin
            $error("normal_z expected %0d got %0d", want.normal_z, normal_z_o); failed = 1'b1;
          end
          if (invalid_o !== want.invalid) begin
            $error("invalid expected %0b got %0b", want.invalid, invalid_o); failed = 1'b1;
          end
        end
      end
      out_ready_i <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  // Write one register and track it in the shadow copy.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_RADIUS:   sph_radius = val[30:0];
      REG_FRAME_X:  sph_frame[0] = val;
      REG_FRAME_Y:  sph_frame[1] = val;
      REG_FRAME_Z:  sph_frame[2] = val;
      REG_CENTER_X: sph_center[0] = val[31:0];
      REG_CENTER_Y: sph_center[1] = val[31:0];
      REG_CENTER_Z: sph_center[2] = val[31:0];
      default: ;
    endcase
  endtask

  // Hold until every queued beat is sent and every result is back, then flush.
  task automatic drain();
    while (pending_probes.size() > 0 || in_valid_i || expected_surface.size() > 0)
      @(posedge clk_i);
    repeat (FLUSH_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [47:0] rand_frame(int style);
    logic [47:0] f;
    f = 48'({$urandom(), $urandom()});
    case (style)
      0: f = {16'sh8000, 16'sh8000, 16'sh8000};   // most negative components
      1: f = {16'sh7fff, 16'sh7fff, 16'sh7fff};
      2: f = {16'($urandom_range(32767) - 16384), 16'($urandom_range(32767) - 16384),
              16'($urandom_range(32767) - 16384)};
      default: ;
    endcase
    return f;
  endfunction

  function automatic probe_t rand_probe();
    probe_t p;
    logic signed [31:0] r;
    p.azimuth = 16'($urandom());
    r = $urandom_range(sph_radius);
    case ($urandom_range(7))
      0: p.height = 0;
      1: p.height = $urandom();
      2: p.height = $urandom_range(1) ? sph_radius : -sph_radius;
      default: p.height = $urandom_range(1) ? r : -r;
    endcase
    return p;
  endfunction

  initial begin
    logic signed [31:0] dir_heights [8];
    logic signed [15:0] dir_angles [8];
    int count;
    sph_radius = RADIUS_RST;
    sph_frame[0] = FRAME_X_RST;
    sph_frame[1] = FRAME_Y_RST;
    sph_frame[2] = FRAME_Z_RST;
    for (int k = 0; k < 3; k++) sph_center[k] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed beats on the reset frame: height at and past the radius, full-scale
    // heights, and azimuths on and just past each quarter turn and at both ends.
    dir_heights = '{32'sd0, 32'sd65536, -32'sd65536, 32'sd65537,
                    32'sh7fffffff, 32'sh80000000, 32'sd32768, -32'sd1};
    dir_angles  = '{16'sd0, 16'sd16384, -16'sd16384, 16'sd16385,
                    -16'sd16385, 16'sh7fff, 16'sh8000, 16'sd8192};
    for (int i = 0; i < 8; i++) begin
      pending_probes.push_back('{dir_heights[i], dir_angles[i]});
      pending_probes.push_back('{dir_heights[7 - i], dir_angles[i]});
    end
    drain();

    // Zero radius with zero height gives a zero local vector; also poke the unused index.
    write_reg(REG_RADIUS, '0);
    write_reg(REG_UNUSED, '1);
    pending_probes.push_back('{32'sd0, 16'sd4000});
    pending_probes.push_back('{32'sd0, 16'sh8000});
    pending_probes.push_back('{32'sd1, 16'sd0});
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      case (phase)
        0: begin
          write_reg(REG_RADIUS, 48'h7fff_ffff);
          write_reg(REG_CENTER_X, 48'h7fff_ffff);
          write_reg(REG_CENTER_Y, 48'h8000_0000);
          write_reg(REG_CENTER_Z, 48'hffff_ffff);
        end
        1: begin
          write_reg(REG_FRAME_X, rand_frame(0));
          write_reg(REG_FRAME_Y, rand_frame(1));
          write_reg(REG_FRAME_Z, rand_frame(0));
        end
        default: begin
          write_reg(REG_RADIUS, $urandom_range(1) ? 48'($urandom_range(100) * 65536)
                                                  : 48'($urandom() >> 1));
          write_reg(REG_FRAME_X, rand_frame($urandom_range(3)));
          write_reg(REG_FRAME_Y, rand_frame($urandom_range(3)));
          write_reg(REG_FRAME_Z, rand_frame($urandom_range(3)));
          write_reg(REG_CENTER_X, 48'($urandom()));
          write_reg(REG_CENTER_Y, $urandom_range(1) ? 48'h0 : 48'($urandom()));
          write_reg(REG_CENTER_Z, 48'($urandom_range(65535) << 16));
        end
      endcase
      count = 0;
      repeat (220) begin
        pending_probes.push_back(rand_probe());
        count++;
        // Once, pause the sender until everything in flight has come back.
        if (phase == 3 && count == 110) drain();
      end
      drain();
    end

    if (!failed) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("testbench failed");
    $finish;
  end

endmodule
